### sv/kcl_pkg.sv
// Shared types and codes for the keypad code lock controller.
package kcl_pkg;

  // Opcodes of an input beat
  localparam logic [2:0] OP_KEY   = 3'd0;
  localparam logic [2:0] OP_CARD  = 3'd1;
  localparam logic [2:0] OP_ECHO  = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_MENU  = 3'd4;

  // Menu choices carried in key_digit
  localparam logic [3:0] MENU_CHANGE   = 4'd1;
  localparam logic [3:0] MENU_RESET    = 4'd2;
  localparam logic [3:0] MENU_ONE_TIME = 4'd3;

  // Lock modes
  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_LOCKOUT    = 3'd1;
  localparam logic [2:0] MODE_CHG_CUR    = 3'd2;
  localparam logic [2:0] MODE_CHG_NEW    = 3'd3;
  localparam logic [2:0] MODE_RST_VERIFY = 3'd4;
  localparam logic [2:0] MODE_RST_NEW    = 3'd5;

  // Events
  localparam logic [3:0] EV_NONE        = 4'd0;
  localparam logic [3:0] EV_OPENED      = 4'd1;
  localparam logic [3:0] EV_CLOSED      = 4'd2;
  localparam logic [3:0] EV_DENIED      = 4'd3;
  localparam logic [3:0] EV_LOCKOUT     = 4'd4;
  localparam logic [3:0] EV_VERIFY_BAD  = 4'd5;
  localparam logic [3:0] EV_VERIFY_OK   = 4'd6;
  localparam logic [3:0] EV_AUTO_CLOSE  = 4'd7;
  localparam logic [3:0] EV_CODE_CHG    = 4'd8;
  localparam logic [3:0] EV_CUR_WRONG   = 4'd9;
  localparam logic [3:0] EV_OT_ARMED    = 4'd10;
  localparam logic [3:0] EV_RST_STARTED = 4'd11;

  // Codes sent to the terminal
  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_LOCKOUT = 2'd1;
  localparam logic [1:0] SEND_RESET   = 2'd2;
  localparam logic [1:0] SEND_ONE_TME = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ONE_TIME   = 3'd0;
  localparam logic [2:0] REG_LOCK_VER   = 3'd1;
  localparam logic [2:0] REG_RST_VER    = 3'd2;
  localparam logic [2:0] REG_CARD_ID    = 3'd3;
  localparam logic [2:0] REG_AWAY_MM    = 3'd4;
  localparam logic [2:0] REG_AWAY_SEC   = 3'd5;
  localparam logic [2:0] REG_MAX_TRIES  = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [15:0] RST_ONE_TIME  = 16'h1313;
  localparam logic [15:0] RST_LOCK_VER  = 16'h3667;
  localparam logic [15:0] RST_RST_VER   = 16'h5656;
  localparam logic [31:0] RST_CARD_ID   = 32'hA7C3_6E4D;
  localparam logic [15:0] RST_AWAY_MM   = 16'd500;
  localparam logic [5:0]  RST_AWAY_SEC  = 6'd15;
  localparam logic [2:0]  RST_MAX_TRIES = 3'd3;

  // Default passcode, digit nibbles
  localparam logic [15:0] RST_PASSCODE = 16'h1234;

  // Echo width to mm: mm = width * ECHO_MUL / ECHO_DIV
  localparam logic [31:0] ECHO_MUL = 32'd170;
  localparam logic [31:0] ECHO_DIV = 32'd1000;
  localparam logic [5:0]  SEC_WRAP = 6'd59;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  key_digit;
    logic [31:0] card_uid;
    logic [23:0] echo_width_us;
  } item_t;

  typedef struct packed {
    logic        valid;
    item_t       item;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] fail_count;
    logic [1:0] digits_entered;
    logic [2:0] lock_mode;
    logic       door_open;
    logic [1:0] send_code;
    logic [3:0] event_res;
  } res_t;

  typedef struct packed {
    logic [15:0] one_time_code;
    logic [15:0] lockout_verify_code;
    logic [15:0] reset_verify_code;
    logic [31:0] card_id;
    logic [15:0] away_distance_mm;
    logic [5:0]  away_seconds;
    logic [2:0]  max_tries;
  } cfg_t;

endpackage

### sv/keypad_code_lock_controller.sv
// Keypad code lock controller: takes one beat per cycle while the output is
// not stalled. Each input beat is held in an input register, then the lock
// state (passcode, entries, mode, door, tries, away timer) is updated by
// combinational logic and the result is written to an output register, so
// one beat per cycle is sustained while the output drains. The combinational
// state update sets that rate. The output register frees as soon as its beat is taken,
// and a stalled output holds the input side after one more beat is buffered.
// Configuration writes take effect at once and belong only to idle periods.
// Codes are CODE_DIGITS digit nibbles; registers supply the low 16 bits.
module keypad_code_lock_controller #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_digit[3:0], card_uid[35:4], echo_width_us[59:36], zeros above
  input  logic [kcl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // event_res[3:0], send_code[5:4], door_open[6], lock_mode[9:7],
  // digits_entered[11:10], fail_count[14:12], zero[15]
  output logic [kcl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import kcl_pkg::*;

  item_t    in_item;
  in_beat_t beat;
  res_t     res, res_q;
  cfg_t     cfg_q;
  logic     fire;
  logic     out_valid_q;

  assign in_item.opcode        = s_axis_tuser;
  assign in_item.key_digit     = s_axis_tdata[3:0];
  assign in_item.card_uid      = s_axis_tdata[35:4];
  assign in_item.echo_width_us = s_axis_tdata[59:36];

  // Advance the held beat when the output register is free or draining
  assign fire = beat.valid && (!out_valid_q || m_axis_tready);

  kcl_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .take_i  (fire),
    .beat_o  (beat)
  );

  kcl_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (beat.item),
    .fire_i (fire),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_time_code       <= RST_ONE_TIME;
      cfg_q.lockout_verify_code <= RST_LOCK_VER;
      cfg_q.reset_verify_code   <= RST_RST_VER;
      cfg_q.card_id             <= RST_CARD_ID;
      cfg_q.away_distance_mm    <= RST_AWAY_MM;
      cfg_q.away_seconds        <= RST_AWAY_SEC;
      cfg_q.max_tries           <= RST_MAX_TRIES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ONE_TIME:  cfg_q.one_time_code       <= cfg_data_i[15:0];
        REG_LOCK_VER:  cfg_q.lockout_verify_code <= cfg_data_i[15:0];
        REG_RST_VER:   cfg_q.reset_verify_code   <= cfg_data_i[15:0];
        REG_CARD_ID:   cfg_q.card_id             <= cfg_data_i;
        REG_AWAY_MM:   cfg_q.away_distance_mm    <= cfg_data_i[15:0];
        REG_AWAY_SEC:  cfg_q.away_seconds        <= cfg_data_i[5:0];
        REG_MAX_TRIES: cfg_q.max_tries           <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.fail_count, res_q.digits_entered, res_q.lock_mode,
                          res_q.door_open, res_q.send_code, res_q.event_res};

endmodule

### sv/kcl_in_stage.sv
// Input register stage: captures one beat and holds it until the core takes it.
module kcl_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  kcl_pkg::item_t   item_i,
  input  logic             take_i,
  output kcl_pkg::in_beat_t beat_o
);
  import kcl_pkg::*;

  logic  valid_q;
  item_t item_q;

  // Refill in the same cycle the core drains the held beat
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.item  = item_q;

endmodule

### sv/kcl_core.sv
// Lock state and the combinational update for one beat.
module kcl_core #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kcl_pkg::cfg_t cfg_i,
  input  kcl_pkg::item_t item_i,
  input  logic          fire_i,
  output kcl_pkg::res_t res_o
);
  import kcl_pkg::*;

  localparam int unsigned CW    = 4 * CODE_DIGITS;
  localparam int unsigned CNT_W = $clog2(CODE_DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS - 1);

  logic [CW-1:0]    pass_q, pass_d;
  logic [CW-1:0]    n_entry_q, n_entry_d;
  logic [CNT_W-1:0] n_cnt_q, n_cnt_d;
  logic [CW-1:0]    m_entry_q, m_entry_d;
  logic [CNT_W-1:0] m_cnt_q, m_cnt_d;
  logic [2:0]       mode_q, mode_d;
  logic             door_q, door_d;
  logic [2:0]       tries_q, tries_d;
  logic             ot_armed_q, ot_armed_d;
  logic [31:0]      card_q, card_d;
  logic             away_q, away_d;
  logic [5:0]       sec_q, sec_d;

  logic [CW-1:0] n_shift, m_shift;
  logic          key_ok;
  logic [2:0]    mode;
  logic [31:0]   echo_prod;
  logic [31:0]   near_lim, far_lim;
  logic          is_near, is_far;
  logic [3:0]    ev;
  logic [1:0]    send;

  assign n_shift = {n_entry_q[CW-5:0], item_i.key_digit};
  assign m_shift = {m_entry_q[CW-5:0], item_i.key_digit};
  assign key_ok  = (item_i.key_digit >= 4'd1) && (item_i.key_digit <= 4'd9);
  assign mode    = (mode_q > MODE_RST_NEW) ? MODE_NORMAL : mode_q;

  // Compare in the scaled domain: floor(w*170/1000) < A  <=>  w*170 < A*1000
  assign echo_prod = 32'(item_i.echo_width_us) * ECHO_MUL;
  assign near_lim  = 32'(cfg_i.away_distance_mm) * ECHO_DIV;
  assign far_lim   = (32'(cfg_i.away_distance_mm) + 32'd1) * ECHO_DIV;
  assign is_near   = echo_prod < near_lim;
  assign is_far    = echo_prod >= far_lim;

  always_comb begin
    logic [5:0] sec_run;
    logic [2:0] tries_inc;
    logic       grant;
    pass_d     = pass_q;
    n_entry_d  = n_entry_q;
    n_cnt_d    = n_cnt_q;
    m_entry_d  = m_entry_q;
    m_cnt_d    = m_cnt_q;
    mode_d     = mode;
    door_d     = door_q;
    tries_d    = tries_q;
    ot_armed_d = ot_armed_q;
    card_d     = card_q;
    away_d     = away_q;
    sec_d      = sec_q;
    ev         = EV_NONE;
    send       = SEND_NONE;
    sec_run    = away_q ? sec_q : 6'd0;
    tries_inc  = tries_q + 3'd1;
    grant      = (n_shift == pass_q)
              || (ot_armed_q && (n_shift == CW'(cfg_i.one_time_code)))
              || (card_q == cfg_i.card_id);

    priority if (item_i.opcode == OP_KEY && key_ok) begin
      if (mode == MODE_NORMAL) begin
        if (n_cnt_q == CNT_LAST) begin
          n_cnt_d   = '0;
          n_entry_d = '0;
          if (grant) begin
            ot_armed_d = 1'b0;
            tries_d    = '0;
            door_d     = !door_q;
            ev         = door_q ? EV_CLOSED : EV_OPENED;
          end else if (tries_inc >= cfg_i.max_tries) begin
            ev        = EV_LOCKOUT;
            send      = SEND_LOCKOUT;
            tries_d   = '0;
            mode_d    = MODE_LOCKOUT;
            m_entry_d = '0;
            m_cnt_d   = '0;
          end else begin
            ev      = EV_DENIED;
            tries_d = tries_inc;
          end
        end else begin
          n_cnt_d   = n_cnt_q + CNT_W'(1);
          n_entry_d = n_shift;
        end
      end else if (m_cnt_q == CNT_LAST) begin
        m_cnt_d   = '0;
        m_entry_d = '0;
        unique case (mode)
          MODE_LOCKOUT: begin
            if (m_shift == CW'(cfg_i.lockout_verify_code)) begin
              ev     = EV_VERIFY_OK;
              mode_d = MODE_NORMAL;
            end else begin
              ev = EV_VERIFY_BAD;
            end
          end
          MODE_CHG_CUR: begin
            if (m_shift == pass_q) mode_d = MODE_CHG_NEW;
            else ev = EV_CUR_WRONG;
          end
          MODE_RST_VERIFY: begin
            if (m_shift == CW'(cfg_i.reset_verify_code)) begin
              ev     = EV_VERIFY_OK;
              mode_d = MODE_RST_NEW;
            end else begin
              ev = EV_VERIFY_BAD;
            end
          end
          default: begin
            pass_d = m_shift;
            ev     = EV_CODE_CHG;
            mode_d = MODE_NORMAL;
          end
        endcase
      end else begin
        m_cnt_d   = m_cnt_q + CNT_W'(1);
        m_entry_d = m_shift;
      end
    end else if (item_i.opcode == OP_CARD && mode == MODE_NORMAL) begin
      card_d = item_i.card_uid;
    end else if (item_i.opcode == OP_ECHO && mode == MODE_NORMAL && door_q) begin
      if (is_near) begin
        sec_d  = '0;
        away_d = 1'b0;
      end
      if (is_far) begin
        sec_d  = sec_run;
        away_d = 1'b1;
        if (sec_run >= cfg_i.away_seconds) begin
          ev     = EV_AUTO_CLOSE;
          door_d = 1'b0;
          away_d = 1'b0;
        end
      end
    end else if (item_i.opcode == OP_TICK) begin
      sec_d = (sec_q >= SEC_WRAP) ? 6'd0 : sec_q + 6'd1;
    end else if (item_i.opcode == OP_MENU && mode == MODE_NORMAL) begin
      if (item_i.key_digit == MENU_CHANGE) begin
        mode_d    = MODE_CHG_CUR;
        m_entry_d = '0;
        m_cnt_d   = '0;
      end else if (item_i.key_digit == MENU_RESET) begin
        mode_d    = MODE_RST_VERIFY;
        m_entry_d = '0;
        m_cnt_d   = '0;
        ev        = EV_RST_STARTED;
        send      = SEND_RESET;
      end else if (item_i.key_digit == MENU_ONE_TIME) begin
        ot_armed_d = 1'b1;
        ev         = EV_OT_ARMED;
        send       = SEND_ONE_TME;
      end
    end else begin
      ev = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q     <= CW'(RST_PASSCODE);
      n_entry_q  <= '0;
      n_cnt_q    <= '0;
      m_entry_q  <= '0;
      m_cnt_q    <= '0;
      mode_q     <= MODE_NORMAL;
      door_q     <= 1'b0;
      tries_q    <= '0;
      ot_armed_q <= 1'b0;
      card_q     <= '0;
      away_q     <= 1'b0;
      sec_q      <= '0;
    end else if (fire_i) begin
      pass_q     <= pass_d;
      n_entry_q  <= n_entry_d;
      n_cnt_q    <= n_cnt_d;
      m_entry_q  <= m_entry_d;
      m_cnt_q    <= m_cnt_d;
      mode_q     <= mode_d;
      door_q     <= door_d;
      tries_q    <= tries_d;
      ot_armed_q <= ot_armed_d;
      card_q     <= card_d;
      away_q     <= away_d;
      sec_q      <= sec_d;
    end
  end

  assign res_o.event_res      = ev;
  assign res_o.send_code      = send;
  assign res_o.door_open      = door_d;
  assign res_o.lock_mode      = mode_d;
  assign res_o.digits_entered = (mode_d == MODE_NORMAL) ? n_cnt_d[1:0] : m_cnt_d[1:0];
  assign res_o.fail_count     = tries_d;

endmodule
